FILE: sv/ddp_pkg.sv
// ----------------------------------------------------------------------------
// ddp_pkg: shared types and constants for the profiled PD drive controller
// Holds the register map, the reset values, the controller states and the
// command and status structures between the controller and the datapath.
// ----------------------------------------------------------------------------
package ddp_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned GAIN_W  = 16;
	localparam int unsigned SHIFT_W = 5;
	localparam int unsigned LIMIT_W = 20;
	localparam int unsigned ADDR_W  = 5;

	// register map, byte address 4*index
	typedef enum logic [2:0] {
		REG_DIST_GAIN_P      = 3'd0,
		REG_DIST_GAIN_D      = 3'd1,
		REG_DIST_OUT_SHIFT   = 3'd2,
		REG_DIST_ACCEL_STEP  = 3'd3,
		REG_DIST_SPEED_LIMIT = 3'd4,
		REG_ANGLE_GAIN_P     = 3'd5,
		REG_ANGLE_GAIN_D     = 3'd6,
		REG_ANGLE_OUT_SHIFT  = 3'd7
	} reg_idx_t;

	localparam logic [GAIN_W-1:0]  RST_DIST_GAIN_P      = 16'd400;
	localparam logic [GAIN_W-1:0]  RST_DIST_GAIN_D      = 16'd1000;
	localparam logic [SHIFT_W-1:0] RST_DIST_OUT_SHIFT   = 5'd14;
	localparam logic [GAIN_W-1:0]  RST_DIST_ACCEL_STEP  = 16'd150;
	localparam logic [LIMIT_W-1:0] RST_DIST_SPEED_LIMIT = 20'd5000;
	localparam logic [GAIN_W-1:0]  RST_ANGLE_GAIN_P     = 16'd200;
	localparam logic [GAIN_W-1:0]  RST_ANGLE_GAIN_D     = 16'd500;
	localparam logic [SHIFT_W-1:0] RST_ANGLE_OUT_SHIFT  = 5'd14;

	typedef struct packed {
		logic [GAIN_W-1:0]  dist_gain_p;
		logic [GAIN_W-1:0]  dist_gain_d;
		logic [SHIFT_W-1:0] dist_out_shift;
		logic [GAIN_W-1:0]  dist_accel_step;
		logic [LIMIT_W-1:0] dist_speed_limit;
		logic [GAIN_W-1:0]  angle_gain_p;
		logic [GAIN_W-1:0]  angle_gain_d;
		logic [SHIFT_W-1:0] angle_out_shift;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_SQUARE,
		OP_DIV_LOAD,
		OP_DIV_STEP,
		OP_PROFILE,
		OP_POSITION,
		OP_ERROR,
		OP_DIFF,
		OP_MUL_PD,
		OP_MUL_DD,
		OP_MUL_PA,
		OP_MUL_DA,
		OP_SUM,
		OP_SHIFT,
		OP_OUTPUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic div_last;
	} sts_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_DIV_LOAD,
		ST_DIV,
		ST_PROFILE,
		ST_POSITION,
		ST_ERROR,
		ST_DIFF,
		ST_MUL_PD,
		ST_MUL_DD,
		ST_MUL_PA,
		ST_MUL_DA,
		ST_SUM,
		ST_SHIFT,
		ST_OUTPUT
	} state_t;

endpackage

FILE: sv/differential_drive_profiled_pd_top.sv
// ----------------------------------------------------------------------------
// differential_drive_profiled_pd_top: trapezoidal profile with distance/angle PD
// A new transaction is accepted only in the idle state, after the previous
// result has been loaded; the stopping-distance divider runs 32 steps.
// Reset (arst_n low) clears profile state, loop history and the output valid.
// ----------------------------------------------------------------------------
module differential_drive_profiled_pd_top
	import ddp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// APB-style configuration port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready,
	// input channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [DATA_W-1:0] measured_distance,
	input  logic signed [DATA_W-1:0] measured_angle,
	input  logic signed [DATA_W-1:0] target_distance,
	input  logic signed [DATA_W-1:0] target_angle,
	// output channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] left_drive,
	output logic signed [DATA_W-1:0] right_drive,
	output logic signed [DATA_W-1:0] dist_drive,
	output logic signed [DATA_W-1:0] angle_drive,
	output logic signed [DATA_W-1:0] profile_position,
	output logic signed [DATA_W-1:0] profile_speed,
	output logic signed [DATA_W-1:0] dist_p_term,
	output logic signed [DATA_W-1:0] dist_d_term,
	output logic signed [DATA_W-1:0] angle_p_term,
	output logic signed [DATA_W-1:0] angle_d_term
);

	// Flow of one tick:
	//   capture -> speed^2 on the shared multiplier -> restoring divide by
	//   2*accel (one quotient bit a cycle) -> accelerate/brake decision ->
	//   position update -> errors -> error deltas -> four gain products on
	//   the same multiplier -> sums -> arithmetic shifts -> output register.
	// The output register holds a finished result while the next transaction
	// is already being computed; only the final load waits for it to drain.

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	ddp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ddp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	ddp_dpath u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.cmd               (cmd),
		.sts               (sts),
		.measured_distance (measured_distance),
		.measured_angle    (measured_angle),
		.target_distance   (target_distance),
		.target_angle      (target_angle),
		.left_drive        (left_drive),
		.right_drive       (right_drive),
		.dist_drive        (dist_drive),
		.angle_drive       (angle_drive),
		.profile_position  (profile_position),
		.profile_speed     (profile_speed),
		.dist_p_term       (dist_p_term),
		.dist_d_term       (dist_d_term),
		.angle_p_term      (angle_p_term),
		.angle_d_term      (angle_d_term)
	);

`ifndef ASSERT_OFF
	// an accepted transaction starts the sequence with the square step
	a_start_square: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (cmd.op == OP_SQUARE))
		else $error("accepted transaction did not start with square step");

	// the output register is never overwritten while a result is held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_OUTPUT) |-> !(out_valid && out_stall))
		else $error("output register loaded while result is stalled");

	// a loaded result is presented on the next cycle
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_OUTPUT) |=> out_valid)
		else $error("loaded result not presented");
`endif

endmodule

FILE: sv/ddp_regs.sv
// ----------------------------------------------------------------------------
// ddp_regs: configuration register file
// APB-style write and read of the eight tuning registers.
// ----------------------------------------------------------------------------
module ddp_regs
	import ddp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dist_gain_p      <= RST_DIST_GAIN_P;
			cfg_q.dist_gain_d      <= RST_DIST_GAIN_D;
			cfg_q.dist_out_shift   <= RST_DIST_OUT_SHIFT;
			cfg_q.dist_accel_step  <= RST_DIST_ACCEL_STEP;
			cfg_q.dist_speed_limit <= RST_DIST_SPEED_LIMIT;
			cfg_q.angle_gain_p     <= RST_ANGLE_GAIN_P;
			cfg_q.angle_gain_d     <= RST_ANGLE_GAIN_D;
			cfg_q.angle_out_shift  <= RST_ANGLE_OUT_SHIFT;
		end else if (wr_en) begin
			unique case (idx)
				REG_DIST_GAIN_P:      cfg_q.dist_gain_p      <= pwdata[GAIN_W-1:0];
				REG_DIST_GAIN_D:      cfg_q.dist_gain_d      <= pwdata[GAIN_W-1:0];
				REG_DIST_OUT_SHIFT:   cfg_q.dist_out_shift   <= pwdata[SHIFT_W-1:0];
				REG_DIST_ACCEL_STEP:  cfg_q.dist_accel_step  <= pwdata[GAIN_W-1:0];
				REG_DIST_SPEED_LIMIT: cfg_q.dist_speed_limit <= pwdata[LIMIT_W-1:0];
				REG_ANGLE_GAIN_P:     cfg_q.angle_gain_p     <= pwdata[GAIN_W-1:0];
				REG_ANGLE_GAIN_D:     cfg_q.angle_gain_d     <= pwdata[GAIN_W-1:0];
				REG_ANGLE_OUT_SHIFT:  cfg_q.angle_out_shift  <= pwdata[SHIFT_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DIST_GAIN_P:      prdata = DATA_W'(cfg_q.dist_gain_p);
			REG_DIST_GAIN_D:      prdata = DATA_W'(cfg_q.dist_gain_d);
			REG_DIST_OUT_SHIFT:   prdata = DATA_W'(cfg_q.dist_out_shift);
			REG_DIST_ACCEL_STEP:  prdata = DATA_W'(cfg_q.dist_accel_step);
			REG_DIST_SPEED_LIMIT: prdata = DATA_W'(cfg_q.dist_speed_limit);
			REG_ANGLE_GAIN_P:     prdata = DATA_W'(cfg_q.angle_gain_p);
			REG_ANGLE_GAIN_D:     prdata = DATA_W'(cfg_q.angle_gain_d);
			REG_ANGLE_OUT_SHIFT:  prdata = DATA_W'(cfg_q.angle_out_shift);
		endcase
	end

endmodule

FILE: sv/ddp_ctrl.sv
// ----------------------------------------------------------------------------
// ddp_ctrl: sequencer for one control tick
// Walks the datapath through square, divide, profile, PD and output steps.
// ----------------------------------------------------------------------------
module ddp_ctrl
	import ddp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output cmd_t cmd,
	input  sts_t sts
);

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_CAPTURE;
					state_d = ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				cmd.op  = OP_SQUARE;
				state_d = ST_DIV_LOAD;
			end
			ST_DIV_LOAD: begin
				cmd.op  = OP_DIV_LOAD;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.op = OP_DIV_STEP;
				if (sts.div_last) state_d = ST_PROFILE;
			end
			ST_PROFILE: begin
				cmd.op  = OP_PROFILE;
				state_d = ST_POSITION;
			end
			ST_POSITION: begin
				cmd.op  = OP_POSITION;
				state_d = ST_ERROR;
			end
			ST_ERROR: begin
				cmd.op  = OP_ERROR;
				state_d = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.op  = OP_DIFF;
				state_d = ST_MUL_PD;
			end
			ST_MUL_PD: begin
				cmd.op  = OP_MUL_PD;
				state_d = ST_MUL_DD;
			end
			ST_MUL_DD: begin
				cmd.op  = OP_MUL_DD;
				state_d = ST_MUL_PA;
			end
			ST_MUL_PA: begin
				cmd.op  = OP_MUL_PA;
				state_d = ST_MUL_DA;
			end
			ST_MUL_DA: begin
				cmd.op  = OP_MUL_DA;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.op  = OP_SUM;
				state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				cmd.op  = OP_SHIFT;
				state_d = ST_OUTPUT;
			end
			ST_OUTPUT: begin
				// wait until the output register is free
				if (!out_valid_q || !out_stall) begin
					cmd.op  = OP_OUTPUT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		if (cmd.op == OP_OUTPUT) out_valid_d = 1'b1;
		else if (!out_stall)     out_valid_d = 1'b0;
		else                     out_valid_d = out_valid_q;
	end

endmodule

FILE: sv/ddp_dpath.sv
// ----------------------------------------------------------------------------
// ddp_dpath: profile and PD datapath
// Shared 32x32 multiplier, radix-2 restoring divider and output register.
// ----------------------------------------------------------------------------
module ddp_dpath
	import ddp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  cmd_t                     cmd,
	output sts_t                     sts,
	input  logic signed [DATA_W-1:0] measured_distance,
	input  logic signed [DATA_W-1:0] measured_angle,
	input  logic signed [DATA_W-1:0] target_distance,
	input  logic signed [DATA_W-1:0] target_angle,
	output logic signed [DATA_W-1:0] left_drive,
	output logic signed [DATA_W-1:0] right_drive,
	output logic signed [DATA_W-1:0] dist_drive,
	output logic signed [DATA_W-1:0] angle_drive,
	output logic signed [DATA_W-1:0] profile_position,
	output logic signed [DATA_W-1:0] profile_speed,
	output logic signed [DATA_W-1:0] dist_p_term,
	output logic signed [DATA_W-1:0] dist_d_term,
	output logic signed [DATA_W-1:0] angle_p_term,
	output logic signed [DATA_W-1:0] angle_d_term
);

	localparam int unsigned REM_W = GAIN_W + 2;
	localparam int unsigned CNT_W = $clog2(DATA_W);
	localparam int unsigned EXT_W = DATA_W + 2;

	function automatic logic [DATA_W-1:0] asr(input logic [DATA_W-1:0] x,
			input logic [SHIFT_W-1:0] s);
		return DATA_W'($signed(x) >>> s);
	endfunction

	// captured tick
	logic [DATA_W-1:0] meas_d_q, meas_a_q, tgt_d_q, tgt_a_q;
	// profile and loop state
	logic [DATA_W-1:0] pos_q, speed_q, last_d_q, last_a_q;
	// working registers
	logic [DATA_W-1:0] sq_q, div_dvd_q;
	logic [REM_W-1:0]  div_rem_q;
	logic              div_neg_q;
	logic [CNT_W-1:0]  div_cnt_q;
	logic [DATA_W-1:0] e_d_q, e_a_q, dd_q, da_q;
	logic [DATA_W-1:0] p_d_q, d_d_q, p_a_q, d_a_q;
	logic [DATA_W-1:0] sum_d_q, sum_a_q, o_d_q, o_a_q;
	logic [DATA_W-1:0] t_pd_q, t_dd_q, t_pa_q, t_da_q;
	// output register
	logic [DATA_W-1:0] left_q, right_q, dist_q, angle_q, opos_q, ospeed_q;
	logic [DATA_W-1:0] opd_q, odd_q, opa_q, oda_q;

	// multiplier
	logic [DATA_W-1:0] mul_a, mul_b, mul_p;

	always_comb begin
		unique case (cmd.op)
			OP_MUL_PD: begin
				mul_a = DATA_W'(cfg.dist_gain_p);
				mul_b = e_d_q;
			end
			OP_MUL_DD: begin
				mul_a = DATA_W'(cfg.dist_gain_d);
				mul_b = dd_q;
			end
			OP_MUL_PA: begin
				mul_a = DATA_W'(cfg.angle_gain_p);
				mul_b = e_a_q;
			end
			OP_MUL_DA: begin
				mul_a = DATA_W'(cfg.angle_gain_d);
				mul_b = da_q;
			end
			default: begin
				mul_a = speed_q;
				mul_b = speed_q;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// divider step
	logic [REM_W-1:0] rem_sh, dvs;
	logic             rem_ge;
	assign rem_sh = {div_rem_q[REM_W-2:0], div_dvd_q[DATA_W-1]};
	assign dvs    = {1'b0, cfg.dist_accel_step, 1'b0};
	assign rem_ge = (rem_sh >= dvs);
	assign sts.div_last = (div_cnt_q == CNT_W'(DATA_W - 1));

	// profile decision
	logic [DATA_W-1:0]       quo;
	logic                    v_pos, add_stop, short_of, below, above;
	logic signed [EXT_W-1:0] pos_x, quo_x, reach, tgt_x, v_x, lim_x;
	always_comb begin
		quo      = (cfg.dist_accel_step == '0) ? '0 : div_dvd_q;
		v_pos    = !speed_q[DATA_W-1] && (speed_q != '0);
		add_stop = v_pos ^ div_neg_q;
		pos_x    = EXT_W'($signed(pos_q));
		quo_x    = $signed(EXT_W'(quo));
		reach    = add_stop ? (pos_x + quo_x) : (pos_x - quo_x);
		tgt_x    = EXT_W'($signed(tgt_d_q));
		short_of = (reach < tgt_x);
		v_x      = EXT_W'($signed(speed_q));
		lim_x    = $signed(EXT_W'(cfg.dist_speed_limit));
		below    = (v_x < lim_x);
		above    = (v_x > -lim_x);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			speed_q  <= '0;
			last_d_q <= '0;
			last_a_q <= '0;
		end else begin
			unique case (cmd.op)
				OP_PROFILE: begin
					if (short_of) begin
						if (below) speed_q <= speed_q + DATA_W'(cfg.dist_accel_step);
					end else begin
						if (above) speed_q <= speed_q - DATA_W'(cfg.dist_accel_step);
					end
				end
				OP_POSITION: pos_q <= pos_q + speed_q;
				OP_DIFF: begin
					last_d_q <= e_d_q;
					last_a_q <= e_a_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_CAPTURE: begin
				meas_d_q <= measured_distance;
				meas_a_q <= measured_angle;
				tgt_d_q  <= target_distance;
				tgt_a_q  <= target_angle;
			end
			OP_SQUARE: sq_q <= mul_p;
			OP_DIV_LOAD: begin
				div_dvd_q <= sq_q[DATA_W-1] ? (~sq_q + DATA_W'(1)) : sq_q;
				div_neg_q <= sq_q[DATA_W-1];
				div_rem_q <= '0;
				div_cnt_q <= '0;
			end
			OP_DIV_STEP: begin
				div_rem_q <= rem_ge ? (rem_sh - dvs) : rem_sh;
				div_dvd_q <= {div_dvd_q[DATA_W-2:0], rem_ge};
				div_cnt_q <= div_cnt_q + CNT_W'(1);
			end
			OP_ERROR: begin
				e_d_q <= pos_q - meas_d_q;
				e_a_q <= tgt_a_q - meas_a_q;
			end
			OP_DIFF: begin
				dd_q <= e_d_q - last_d_q;
				da_q <= e_a_q - last_a_q;
			end
			OP_MUL_PD: p_d_q <= mul_p;
			OP_MUL_DD: d_d_q <= mul_p;
			OP_MUL_PA: p_a_q <= mul_p;
			OP_MUL_DA: d_a_q <= mul_p;
			OP_SUM: begin
				sum_d_q <= p_d_q + d_d_q;
				sum_a_q <= p_a_q + d_a_q;
			end
			OP_SHIFT: begin
				o_d_q  <= asr(sum_d_q, cfg.dist_out_shift);
				o_a_q  <= asr(sum_a_q, cfg.angle_out_shift);
				t_pd_q <= asr(p_d_q, cfg.dist_out_shift);
				t_dd_q <= asr(d_d_q, cfg.dist_out_shift);
				t_pa_q <= asr(p_a_q, cfg.angle_out_shift);
				t_da_q <= asr(d_a_q, cfg.angle_out_shift);
			end
			OP_OUTPUT: begin
				left_q   <= o_d_q - o_a_q;
				right_q  <= o_d_q + o_a_q;
				dist_q   <= o_d_q;
				angle_q  <= o_a_q;
				opos_q   <= pos_q;
				ospeed_q <= speed_q;
				opd_q    <= t_pd_q;
				odd_q    <= t_dd_q;
				opa_q    <= t_pa_q;
				oda_q    <= t_da_q;
			end
			default: ;
		endcase
	end

	assign left_drive       = $signed(left_q);
	assign right_drive      = $signed(right_q);
	assign dist_drive       = $signed(dist_q);
	assign angle_drive      = $signed(angle_q);
	assign profile_position = $signed(opos_q);
	assign profile_speed    = $signed(ospeed_q);
	assign dist_p_term      = $signed(opd_q);
	assign dist_d_term      = $signed(odd_q);
	assign angle_p_term     = $signed(opa_q);
	assign angle_d_term     = $signed(oda_q);

endmodule
